>>> rtl/cvtp_pkg.sv
// Package for the constant velocity track predictor: widths, codes, state type.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cvtp_pkg;

	localparam int MAX_OBJECTS_DEF = 8;
	localparam int OBJ_LIMIT       = 8;
	localparam int N_AXES          = 3;
	localparam int POS_W           = 32;
	localparam int TIME_W          = 32;
	localparam int ICPT_W          = 48;
	localparam int VEL_W           = 32;
	localparam int DIVIDEND_W      = 64;
	localparam int DIVISOR_W       = 32;
	localparam int SKIP_W          = 8;
	localparam int ACT_W           = 4;
	localparam int CFG_IDX_W       = 2;

	localparam logic FUNC_POSE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SKIP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd1;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_FEW = 2'd1;
	localparam logic [1:0] ST_EQT = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_MUL1,
		S_MUL2,
		S_ISUB,
		S_IDIV,
		S_ISAT,
		S_VSET,
		S_VDIV,
		S_VSAT,
		S_EMIT
	} cvtp_state_t;

endpackage
`default_nettype wire

>>> rtl/cvtp_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on cvtp_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none
module cvtp_div
	import cvtp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       done,
	output logic [DIVIDEND_W-1:0]      quotient
);
	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic                  busy_q, done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q, div_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    shifted, trial;
	logic                  ge;

	always_comb begin
		shifted = {rem_q, quo_q[DIVIDEND_W-1]};
		ge      = (shifted >= {1'b0, div_q});
		trial   = ge ? (shifted - {1'b0, div_q}) : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

>>> rtl/constant_velocity_track_predictor.sv
// Top level of the constant velocity track predictor.
// Depends on cvtp_pkg and instantiates the shared divider cvtp_div.
//
// Usage:
//  - Request channel: start with func/obj/pos_x/pos_y/pos_z/time_ms, taken when
//    start is high and busy is low.
//  - A pose request (func 0) is handled in the cycle it is taken and yields no result;
//    busy stays low, so poses may come every cycle.
//  - A predict request (func 1) raises busy and walks the reported objects one
//    at a time. Each result is shown for one cycle with result_valid high;
//    last marks the final one. With no active objects nothing is emitted.
//  - Steps of a tick: an object with a fit is loaded; each of the 3 axes then
//    runs 2 multiplies, 1 subtract, an intercept divide and saturate, then a
//    velocity setup, divide and saturate; then the object is emitted. An object
//    with an error status goes from load to emit. Each result appears the
//    cycle after its emit. Divides use the single 64-bit restoring divider.
//  - The receiver cannot stall: results go out on fixed cycles.
//  - Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//    is always high. Write only while idle.
//  - Reset clears the skip counters, the sample counts, the active count and
//    the sequencer, and sets the skip interval to 1; the pose and time stores
//    come up undefined and are read only after two kept poses.
`timescale 1ns / 1ps
`default_nettype none
module constant_velocity_track_predictor
	import cvtp_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  func,
	input  wire logic [2:0]            obj,
	input  wire logic signed [POS_W-1:0] pos_x,
	input  wire logic signed [POS_W-1:0] pos_y,
	input  wire logic signed [POS_W-1:0] pos_z,
	input  wire logic [TIME_W-1:0]     time_ms,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [SKIP_W-1:0]     cfg_data,
	output logic                       result_valid,
	output logic [2:0]                 result_obj,
	output logic [1:0]                 status,
	output logic signed [ICPT_W-1:0]   icpt_x,
	output logic signed [ICPT_W-1:0]   icpt_y,
	output logic signed [ICPT_W-1:0]   icpt_z,
	output logic signed [VEL_W-1:0]    vel_x,
	output logic signed [VEL_W-1:0]    vel_y,
	output logic signed [VEL_W-1:0]    vel_z,
	output logic [TIME_W-1:0]          fit_start_ms,
	output logic [TIME_W-1:0]          fit_end_ms,
	output logic                       last
);
	// Objects beyond the object port's reach can never be addressed.
	localparam int NOBJ  = (MAX_OBJECTS > OBJ_LIMIT) ? OBJ_LIMIT : MAX_OBJECTS;
	localparam int IDX_W = (NOBJ > 1) ? $clog2(NOBJ) : 1;
	localparam int CNT_W = $clog2(NOBJ + 1);
	localparam int PROD_W = POS_W + TIME_W;
	localparam int VNUM_W = POS_W + 1 + 10;

	// Configuration registers
	logic [SKIP_W-1:0] skip_int_q;
	logic [ACT_W-1:0]  active_q;

	// Per-object track state
	logic [SKIP_W-1:0] skip_cnt_q [NOBJ];
	logic [1:0]        samp_q     [NOBJ];
	logic [POS_W-1:0]  newer_pos_q [NOBJ][N_AXES];
	logic [POS_W-1:0]  older_pos_q [NOBJ][N_AXES];
	logic [TIME_W-1:0] newer_time_q [NOBJ];
	logic [TIME_W-1:0] older_time_q [NOBJ];

	// Sequencer and work registers
	cvtp_state_t state_q, state_d;
	logic [CNT_W-1:0]  obj_q, count_q;
	logic [1:0]        axis_q;
	logic [1:0]        stat_q;
	logic [TIME_W-1:0] t1_q, t2_q;
	logic signed [PROD_W:0] p1_q, p2_q;
	logic              neg_q;
	logic signed [ICPT_W-1:0] icpt_q [N_AXES];
	logic signed [VEL_W-1:0]  vel_q  [N_AXES];

	// Result registers
	logic              rv_q, last_q;
	logic [2:0]        robj_q;
	logic [1:0]        rstat_q;
	logic [ICPT_W-1:0] ricpt_q [N_AXES];
	logic [VEL_W-1:0]  rvel_q  [N_AXES];
	logic [TIME_W-1:0] rt1_q, rt2_q;

	logic accept, pose_acc, tick_acc, pose_ok;
	logic [IDX_W-1:0]  pidx, widx;
	logic [SKIP_W-1:0] skip_next;
	logic [POS_W-1:0]  pin [N_AXES];
	logic [CNT_W-1:0]  tick_count;

	logic signed [POS_W-1:0] q1, q2;
	logic [POS_W-1:0]        mul_a;
	logic [TIME_W-1:0]       mul_b;
	logic [PROD_W-1:0]       prod;
	logic                    mul_neg;
	logic signed [PROD_W:0]  prod_s;
	logic                    tneg;
	logic [DIVISOR_W-1:0]    dt_mag;
	logic signed [PROD_W+1:0] idiff;
	logic [DIVIDEND_W-1:0]   imag;
	logic signed [POS_W:0]   vd;
	logic [POS_W:0]          vmag;
	logic [VNUM_W-1:0]       vnum;

	logic                    div_start, div_done;
	logic [DIVIDEND_W-1:0]   div_dividend, div_quo;
	logic signed [ICPT_W-1:0] icpt_sat;
	logic signed [VEL_W-1:0]  vel_sat;
	logic                    last_obj;

	assign accept    = start && !busy;
	assign pose_acc  = accept && (func == FUNC_POSE);
	assign tick_acc  = accept && (func == FUNC_TICK);
	assign pose_ok   = (32'(obj) < NOBJ);
	assign pidx      = obj[IDX_W-1:0];
	assign widx      = obj_q[IDX_W-1:0];
	assign skip_next = skip_cnt_q[pidx] + 1'b1;
	assign pin[0]    = pos_x;
	assign pin[1]    = pos_y;
	assign pin[2]    = pos_z;
	assign tick_count = (32'(active_q) > NOBJ) ? CNT_W'(NOBJ) : CNT_W'(active_q);
	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE);
	assign last_obj  = (obj_q + 1'b1 == count_q);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_int_q <= SKIP_W'(1);
			active_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SKIP:   skip_int_q <= cfg_data;
				CFG_ACTIVE: active_q   <= cfg_data[ACT_W-1:0];
				default:    ;
			endcase
		end
	end

	// Skip counter and sample count: advance the counter, keep the pose when
	// it reaches the interval (an interval of zero keeps every pose).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NOBJ; i++) begin
				skip_cnt_q[i] <= '0;
				samp_q[i]     <= '0;
			end
		end else if (pose_acc && pose_ok) begin
			if (skip_next < skip_int_q) begin
				skip_cnt_q[pidx] <= skip_next;
			end else begin
				skip_cnt_q[pidx] <= '0;
				if (samp_q[pidx] != 2'd2)
					samp_q[pidx] <= samp_q[pidx] + 1'b1;
			end
		end
	end

	// Pose stores: shift newer into older on a kept pose
	always_ff @(posedge clk) begin
		if (pose_acc && pose_ok && !(skip_next < skip_int_q)) begin
			for (int a = 0; a < N_AXES; a++) begin
				older_pos_q[pidx][a] <= newer_pos_q[pidx][a];
				newer_pos_q[pidx][a] <= pin[a];
			end
			older_time_q[pidx] <= newer_time_q[pidx];
			newer_time_q[pidx] <= time_ms;
		end
	end

	// Datapath of the current axis
	always_comb begin
		q1      = older_pos_q[widx][axis_q];
		q2      = newer_pos_q[widx][axis_q];
		mul_a   = (state_q == S_MUL1) ? (q1[POS_W-1] ? -q1 : q1) : (q2[POS_W-1] ? -q2 : q2);
		mul_b   = (state_q == S_MUL1) ? t2_q : t1_q;
		mul_neg = (state_q == S_MUL1) ? q1[POS_W-1] : q2[POS_W-1];
		prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
		prod_s  = mul_neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
		tneg    = (t2_q < t1_q);
		dt_mag  = tneg ? (t1_q - t2_q) : (t2_q - t1_q);
		idiff   = (PROD_W+2)'(p1_q) - (PROD_W+2)'(p2_q);
		imag    = idiff[PROD_W+1] ? DIVIDEND_W'(-idiff) : DIVIDEND_W'(idiff);
		vd      = (POS_W+1)'(q2) - (POS_W+1)'(q1);
		vmag    = vd[POS_W] ? -vd : vd;
		// times 1000 as 1024 - 16 - 8
		vnum    = (VNUM_W'(vmag) << 10) - (VNUM_W'(vmag) << 4) - (VNUM_W'(vmag) << 3);
		div_start    = (state_q == S_ISUB) || (state_q == S_VSET);
		div_dividend = (state_q == S_ISUB) ? imag : DIVIDEND_W'(vnum);

		if (neg_q) begin
			if (div_quo > DIVIDEND_W'(64'h0000_8000_0000_0000))
				icpt_sat = {1'b1, {(ICPT_W-1){1'b0}}};
			else
				icpt_sat = -div_quo[ICPT_W-1:0];
			if (div_quo > DIVIDEND_W'(64'h0000_0000_8000_0000))
				vel_sat = {1'b1, {(VEL_W-1){1'b0}}};
			else
				vel_sat = -div_quo[VEL_W-1:0];
		end else begin
			if (div_quo > DIVIDEND_W'(64'h0000_7FFF_FFFF_FFFF))
				icpt_sat = {1'b0, {(ICPT_W-1){1'b1}}};
			else
				icpt_sat = div_quo[ICPT_W-1:0];
			if (div_quo > DIVIDEND_W'(64'h0000_0000_7FFF_FFFF))
				vel_sat = {1'b0, {(VEL_W-1){1'b1}}};
			else
				vel_sat = div_quo[VEL_W-1:0];
		end
	end

	cvtp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (dt_mag),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Next state: load an object, branch on its status, run the axes, emit
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (tick_acc && (tick_count != '0)) state_d = S_LOAD;
			S_LOAD: begin
				if (samp_q[widx] != 2'd2)
					state_d = S_EMIT;
				else if (older_time_q[widx] == newer_time_q[widx])
					state_d = S_EMIT;
				else
					state_d = S_MUL1;
			end
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_ISUB;
			S_ISUB: state_d = S_IDIV;
			S_IDIV: if (div_done) state_d = S_ISAT;
			S_ISAT: state_d = S_VSET;
			S_VSET: state_d = S_VDIV;
			S_VDIV: if (div_done) state_d = S_VSAT;
			S_VSAT: state_d = (axis_q == 2'(N_AXES - 1)) ? S_EMIT : S_MUL1;
			S_EMIT: state_d = last_obj ? S_IDLE : S_LOAD;
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_q   <= '0;
			count_q <= '0;
			axis_q  <= '0;
			rv_q    <= 1'b0;
		end else begin
			rv_q <= (state_q == S_EMIT);
			if (tick_acc) begin
				obj_q   <= '0;
				count_q <= tick_count;
			end else if (state_q == S_EMIT) begin
				obj_q <= obj_q + 1'b1;
			end
			if (state_q == S_LOAD)
				axis_q <= '0;
			else if (state_q == S_VSAT)
				axis_q <= axis_q + 1'b1;
		end
	end

	// Work registers: hold the times and the axis results of one object
	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				t1_q <= older_time_q[widx];
				t2_q <= newer_time_q[widx];
				for (int a = 0; a < N_AXES; a++) begin
					icpt_q[a] <= '0;
					vel_q[a]  <= '0;
				end
				if (samp_q[widx] != 2'd2)
					stat_q <= ST_FEW;
				else if (older_time_q[widx] == newer_time_q[widx])
					stat_q <= ST_EQT;
				else
					stat_q <= ST_OK;
			end
			S_MUL1: p1_q <= prod_s;
			S_MUL2: p2_q <= prod_s;
			S_ISUB: neg_q <= idiff[PROD_W+1] ^ tneg;
			S_ISAT: icpt_q[axis_q] <= icpt_sat;
			S_VSET: neg_q <= vd[POS_W] ^ tneg;
			S_VSAT: vel_q[axis_q] <= vel_sat;
			default: ;
		endcase
	end

	// Result registers: drop the times when fewer than two poses are held
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT) begin
			robj_q  <= 3'(obj_q);
			rstat_q <= stat_q;
			last_q  <= last_obj;
			rt1_q   <= (stat_q == ST_FEW) ? '0 : t1_q;
			rt2_q   <= (stat_q == ST_FEW) ? '0 : t2_q;
			for (int a = 0; a < N_AXES; a++) begin
				ricpt_q[a] <= icpt_q[a];
				rvel_q[a]  <= vel_q[a];
			end
		end
	end

	assign result_valid = rv_q;
	assign result_obj   = robj_q;
	assign status       = rstat_q;
	assign icpt_x       = ricpt_q[0];
	assign icpt_y       = ricpt_q[1];
	assign icpt_z       = ricpt_q[2];
	assign vel_x        = rvel_q[0];
	assign vel_y        = rvel_q[1];
	assign vel_z        = rvel_q[2];
	assign fit_start_ms = rt1_q;
	assign fit_end_ms   = rt2_q;
	assign last         = last_q;

endmodule
`default_nettype wire

>>> rtl/cvtp_chk.sv
// Port-level checker for the track predictor, bound to the top level.
// Depends on cvtp_pkg for the status codes, the function code and the time width.
`timescale 1ns / 1ps
`default_nettype none
module cvtp_chk
	import cvtp_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              func,
	input wire logic              result_valid,
	input wire logic [1:0]        status,
	input wire logic [TIME_W-1:0] fit_start_ms,
	input wire logic [TIME_W-1:0] fit_end_ms,
	input wire logic              last
);
	a_res_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result outside a predict request");

	// A new request may be taken while the final result is shown
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |=> !result_valid)
		else $error("result after the final result");

	a_pose_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_POSE) |=> !busy)
		else $error("pose request raised busy");

	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == ST_FEW) |-> (fit_start_ms == '0 && fit_end_ms == '0))
		else $error("times shown without two poses");

endmodule

bind constant_velocity_track_predictor cvtp_chk u_cvtp_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.func         (func),
	.result_valid (result_valid),
	.status       (status),
	.fit_start_ms (fit_start_ms),
	.fit_end_ms   (fit_end_ms),
	.last         (last)
);
`default_nettype wire
